// ===== src/ili_pkg.sv =====
package ili_pkg;

   localparam int CAPACITY = 32;
   localparam int VALUE_W  = 32;
   localparam int POS_W    = 6;
   localparam int ACTION_W = 3;
   localparam int STATUS_W = 2;

   localparam logic [POS_W-1:0] COUNT_MAX = POS_W'(CAPACITY);

   typedef enum logic [ACTION_W-1:0] {
      ACT_READ   = 3'd0,
      ACT_HEAD   = 3'd1,
      ACT_TAIL   = 3'd2,
      ACT_AT     = 3'd3,
      ACT_DELETE = 3'd4
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_RANGE = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // broadcast to every cell of the row
   typedef struct packed {
      logic               insert;
      logic               remove;
      logic [POS_W-1:0]   slot;
      logic [VALUE_W-1:0] value;
   } cell_ctrl_type;

endpackage

// ===== src/ili_cell.sv =====
module ili_cell (
   input  logic                        clock,
   input  logic [ili_pkg::POS_W-1:0]   cell_index,
   input  ili_pkg::cell_ctrl_type      ctrl,
   input  logic [ili_pkg::VALUE_W-1:0] lower_value,
   input  logic [ili_pkg::VALUE_W-1:0] upper_value,
   input  logic [ili_pkg::POS_W-1:0]   read_pos,
   output logic [ili_pkg::VALUE_W-1:0] value,
   output logic [ili_pkg::VALUE_W-1:0] read_term
);
   import ili_pkg::*;

   logic [VALUE_W-1:0] value_ff;
   logic [VALUE_W-1:0] value_in;
   logic               at_slot;
   logic               above_slot;

   assign at_slot    = (cell_index == ctrl.slot);
   assign above_slot = (cell_index > ctrl.slot);

   always_comb begin
      value_in = value_ff;
      priority if (ctrl.insert && at_slot) begin
         value_in = ctrl.value;
      end else if (ctrl.insert && above_slot) begin
         // entries above the gap move up one cell
         value_in = lower_value;
      end else if (ctrl.remove && (at_slot || above_slot)) begin
         value_in = upper_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value     = value_ff;
   assign read_term = (cell_index == read_pos) ? value_ff : '0;

endmodule

// ===== src/indexed_list_insert_delete_top.sv =====
// ordered list of up to 32 signed 32-bit entries kept in a row of cells
// input channel req_*: action, position, value; one result item per request
// result channel rsp_*: read_value, status, length after the request
// every cell compares its own index with the request slot and shifts data
// to or from its neighbor in the same cycle, so a request completes on
// acceptance: the result item shows on rsp_* the cycle after acceptance
// throughput is one item per cycle while rsp_ready stays high
// when the receiver stalls, the result is held in the output register and
// req_ready drops until it is taken; a new item is accepted in the same
// cycle the waiting result leaves
// reset (synchronous, active high) empties the list and drops rsp_valid;
// entry contents are not cleared, reads never reach unwritten slots
module indexed_list_insert_delete_top (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ili_pkg::ACTION_W-1:0] req_action,
   input  logic [ili_pkg::POS_W-1:0]    req_position,
   input  logic signed [ili_pkg::VALUE_W-1:0] req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ili_pkg::VALUE_W-1:0] rsp_read_value,
   output logic [ili_pkg::STATUS_W-1:0] rsp_status,
   output logic [ili_pkg::POS_W-1:0]    rsp_length
);
   import ili_pkg::*;

   logic                 accept;
   logic [POS_W-1:0]     count_ff;
   logic [POS_W-1:0]     count_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [VALUE_W-1:0]   rsp_read_value_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [POS_W-1:0]     rsp_length_ff;

   cell_ctrl_type        ctrl;
   status_type           status;
   logic                 do_read;
   logic                 full;
   logic [VALUE_W-1:0]   read_data;
   logic [VALUE_W-1:0]   cell_value [CAPACITY];
   logic [VALUE_W-1:0]   read_term  [CAPACITY];
   logic [VALUE_W-1:0]   lower_value [CAPACITY];
   logic [VALUE_W-1:0]   upper_value [CAPACITY];

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff == COUNT_MAX);

   always_comb begin
      ctrl.insert = 1'b0;
      ctrl.remove = 1'b0;
      ctrl.slot   = req_position;
      ctrl.value  = req_value;
      status      = ST_DONE;
      do_read     = 1'b0;
      unique case (action_type'(req_action))
         ACT_READ: begin
            if (req_position < count_ff) begin
               do_read = 1'b1;
            end else begin
               status = ST_RANGE;
            end
         end
         ACT_HEAD: begin
            ctrl.slot = '0;
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = accept;
            end
         end
         ACT_TAIL: begin
            ctrl.slot = count_ff;
            if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = accept;
            end
         end
         ACT_AT: begin
            // range check comes before the full check
            if (req_position > count_ff) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               ctrl.insert = accept;
            end
         end
         ACT_DELETE: begin
            if (req_position < count_ff) begin
               ctrl.remove = accept;
            end else begin
               status = ST_RANGE;
            end
         end
         default: begin
            status = ST_DONE;
         end
      endcase
   end

   // neighbor links, open at both ends of the row
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         lower_value[i] = (i == 0) ? '0 : cell_value[(i == 0) ? 0 : i - 1];
         upper_value[i] = (i == CAPACITY - 1) ? '0
                                              : cell_value[(i == CAPACITY - 1) ? i : i + 1];
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      ili_cell u_cell (
         .clock       (clock),
         .cell_index  (POS_W'(g)),
         .ctrl        (ctrl),
         .lower_value (lower_value[g]),
         .upper_value (upper_value[g]),
         .read_pos    (req_position),
         .value       (cell_value[g]),
         .read_term   (read_term[g])
      );
   end

   always_comb begin
      read_data = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_data = read_data | read_term[i];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + POS_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - POS_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_value_ff <= do_read ? read_data : '0;
         rsp_status_ff     <= status;
         rsp_length_ff     <= count_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;

endmodule

// ===== src/ili_checker.sv =====
module ili_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [ili_pkg::VALUE_W-1:0]  rsp_read_value,
   input logic [ili_pkg::STATUS_W-1:0] rsp_status,
   input logic [ili_pkg::POS_W-1:0]    rsp_length
);
   import ili_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value)
         && $stable(rsp_status) && $stable(rsp_length))
      else $error("result item changed while stalled");

   a_length_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_length <= COUNT_MAX)
      else $error("length above capacity");

   a_full_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FULL |-> rsp_length == COUNT_MAX)
      else $error("full status with list not full");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_DONE |-> rsp_read_value == '0)
      else $error("read value on a failed item");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_DONE || rsp_status == ST_RANGE
         || rsp_status == ST_FULL)
      else $error("unknown status code");

endmodule

bind indexed_list_insert_delete_top ili_checker u_ili_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_read_value (rsp_read_value),
   .rsp_status     (rsp_status),
   .rsp_length     (rsp_length)
);
